/* hdl/jbhe_pkg.sv */
// shared types, constants and helper functions of the block huffman encoder
// no dependencies; used by every module of the encoder except jbhe_ram
`timescale 1ns / 1ps

package jbhe_pkg;

	// item kinds carried in s_tuser
	typedef enum logic [1:0] {
		OP_LOAD_DC = 2'd0,
		OP_LOAD_AC = 2'd1,
		OP_COEF    = 2'd2,
		OP_FLUSH   = 2'd3
	} opcode_t;

	// front sequencer states
	typedef enum logic [2:0] {
		F_IDLE,
		F_DC_CODE,
		F_AC_CODE,
		F_VAL,
		F_FLUSH
	} front_state_t;

	// byte packer states
	typedef enum logic [1:0] {
		B_LOAD,
		B_DRAIN,
		B_STUFF
	} back_state_t;

	// one bit chunk handed from the front to the packer
	typedef struct packed {
		logic [15:0] bits;
		logic [4:0]  len;
		logic        flush;
		logic        eoi;
	} chunk_t;

	localparam int ChunkWidth = $bits(chunk_t);
	localparam int QUEUE_DEPTH = 4;
	localparam int AcDepth = 256;
	localparam int DcDepth = 16;
	localparam int AcWidth = 21;

	localparam logic [7:0] ZRL_SYM    = 8'd240;
	localparam logic [7:0] EOB_SYM    = 8'd0;
	localparam logic [5:0] LAST_POS   = 6'd63;
	localparam logic [4:0] MAX_LEN    = 5'd16;
	localparam logic [7:0] STUFF_BYTE = 8'hff;

	// bit length of a magnitude
	function automatic logic [3:0] category(input logic [11:0] mag);
		logic [3:0] s;
		s = 4'd0;
		for (int i = 0; i < 12; i++) begin
			if (mag[i])
				s = 4'(i + 1);
		end
		return s;
	endfunction

	// keep the low len bits of a code
	function automatic logic [15:0] code_mask(input logic [15:0] code, input logic [4:0] len);
		logic [16:0] m;
		m = ~(17'h1ffff << len);
		return code & m[15:0];
	endfunction

endpackage

/* hdl/jpeg_block_huffman_encoder.sv */
// top level of the jpeg baseline huffman entropy encoder
// depends on jbhe_pkg, jbhe_front, jbhe_queue and jbhe_back
`timescale 1ns / 1ps

// Items on the slave stream load DC or AC Huffman table entries, code one quantized
// zig-zag coefficient (64 per block), or flush the bit packer; the master stream
// carries the coded bytes with a 0x00 after every 0xFF, and tlast marks the final
// byte caused by each item. The front sequencer takes a new item only when it is idle
// and turns each coefficient into chunks (DC: code and value bits; AC: each ZRL, the
// run/size code and the value bits; EOB: its code; a zero inside a run: nothing);
// a flush gives one flush chunk. Chunks wait in a short queue, and the byte packer
// takes each chunk, then drains its bytes, stuffing bytes included; when the queue
// fills, the front waits for it.
module jpeg_block_huffman_encoder #(
	parameter int QUEUE_DEPTH = jbhe_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// coefficient[10:0], symbol[18:11], code_bits[34:19], code_length[39:35]
	input  logic [39:0] s_tdata,
	// opcode[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// out_byte[7:0]
	output logic [7:0]  m_tdata,
	output logic        m_tlast
);
	import jbhe_pkg::*;

	logic   q_push;
	logic   q_pop;
	logic   q_full;
	logic   q_empty;
	chunk_t q_wr;
	chunk_t q_rd;

	jbhe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_chunk  (q_wr)
	);

	jbhe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_chunk (q_wr),
		.full     (q_full),
		.pop      (q_pop),
		.rd_chunk (q_rd),
		.empty    (q_empty)
	);

	jbhe_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_head   (q_rd),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

/* hdl/jbhe_ram.sv */
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module jbhe_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic                 re,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem_q [D];
	logic [W-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* hdl/jbhe_queue.sv */
// short chunk queue between the coefficient front and the byte packer
// depends on jbhe_pkg
`timescale 1ns / 1ps

module jbhe_queue #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  jbhe_pkg::chunk_t wr_chunk,
	output logic            full,
	input  logic            pop,
	output jbhe_pkg::chunk_t rd_chunk,
	output logic            empty
);
	import jbhe_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	chunk_t          slot_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign rd_chunk = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= wr_chunk;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

/* hdl/jbhe_front.sv */
// front part: accepts items, keeps the code tables and the block state,
// turns each coefficient into bit chunks; depends on jbhe_pkg and jbhe_ram
`timescale 1ns / 1ps

module jbhe_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [39:0]      s_tdata,
	input  logic [1:0]       s_tuser,
	input  logic             q_full,
	output logic             q_push,
	output jbhe_pkg::chunk_t q_chunk
);
	import jbhe_pkg::*;

	front_state_t state_q, state_d;
	logic [5:0]   pos_q;
	logic [5:0]   run_q;
	logic [10:0]  prev_q;
	logic [15:0]  dc_code_q [DcDepth];
	logic [4:0]   dc_len_q [DcDepth];
	logic         ac_valid_q [AcDepth];
	logic         rd_valid_q;
	logic [15:0]  val_q;
	logic [3:0]   cat_q;
	logic         zrl_q;
	logic         eob_q;

	opcode_t             op;
	logic signed [10:0]  coef;
	logic [7:0]          sym;
	logic [15:0]         code;
	logic [4:0]          len;
	logic                accept;
	logic [11:0]         x12;
	logic [11:0]         mag;
	logic [11:0]         vraw;
	logic [3:0]          cat;
	logic [11:0]         vmask;
	logic                ram_re;
	logic [7:0]          ram_raddr;
	logic [AcWidth-1:0]  ram_rdata;
	logic                ram_we;
	logic [4:0]          ac_len;
	logic [5:0]          run_next;
	logic                coef_dc;
	logic                coef_ac_read;

	// field unpacking
	assign op   = opcode_t'(s_tuser);
	assign coef = s_tdata[10:0];
	assign sym  = s_tdata[18:11];
	assign code = s_tdata[34:19];
	assign len  = s_tdata[39:35];

	assign s_tready = (state_q == F_IDLE);
	assign accept   = s_tvalid && s_tready;

	// dc difference or ac value, its category and its value bits
	always_comb begin
		if (pos_q == '0)
			x12 = {coef[10], coef} - {prev_q[10], prev_q};
		else
			x12 = {coef[10], coef};
		mag   = x12[11] ? (12'd0 - x12) : x12;
		vraw  = x12[11] ? (x12 - 12'd1) : x12;
		cat   = category(mag);
		vmask = vraw & ~(12'hfff << cat);
	end

	assign coef_dc      = accept && (op == OP_COEF) && (pos_q == '0);
	assign coef_ac_read = accept && (op == OP_COEF) && (pos_q != '0)
		&& ((coef != '0) || (pos_q == LAST_POS));

	// ac table read address: zrl while the run is long, else run/size or eob
	assign run_next = run_q - 6'd16;
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = EOB_SYM;
		if (coef_ac_read) begin
			ram_re = 1'b1;
			if (coef == '0)
				ram_raddr = EOB_SYM;
			else if (run_q > 6'd15)
				ram_raddr = ZRL_SYM;
			else
				ram_raddr = {run_q[3:0], cat};
		end else if (state_q == F_AC_CODE && zrl_q && !q_full) begin
			ram_re    = 1'b1;
			ram_raddr = (run_next > 6'd15) ? ZRL_SYM : {run_next[3:0], cat_q};
		end
	end

	assign ram_we = accept && (op == OP_LOAD_AC) && (len <= MAX_LEN);

	jbhe_ram #(
		.W (AcWidth),
		.D (AcDepth)
	) u_ac_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (sym),
		.wdata ({code, len}),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign ac_len = rd_valid_q ? ram_rdata[4:0] : 5'd0;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE: begin
				if (accept) begin
					if (op == OP_FLUSH)
						state_d = F_FLUSH;
					else if (coef_dc)
						state_d = F_DC_CODE;
					else if (coef_ac_read)
						state_d = F_AC_CODE;
				end
			end
			F_DC_CODE: begin
				if (!q_full)
					state_d = F_VAL;
			end
			F_AC_CODE: begin
				if (!q_full && !zrl_q)
					state_d = eob_q ? F_IDLE : F_VAL;
			end
			F_VAL, F_FLUSH: begin
				if (!q_full)
					state_d = F_IDLE;
			end
			default: state_d = F_IDLE;
		endcase
	end

	// chunk output
	always_comb begin
		q_push  = 1'b0;
		q_chunk = '0;
		case (state_q)
			F_DC_CODE: begin
				q_push        = !q_full;
				q_chunk.len   = dc_len_q[cat_q];
				q_chunk.bits  = code_mask(dc_code_q[cat_q], dc_len_q[cat_q]);
			end
			F_AC_CODE: begin
				q_push        = !q_full;
				q_chunk.len   = ac_len;
				q_chunk.bits  = code_mask(ram_rdata[AcWidth-1:5], ac_len);
				q_chunk.eoi   = eob_q;
			end
			F_VAL: begin
				q_push        = !q_full;
				q_chunk.len   = {1'b0, cat_q};
				q_chunk.bits  = val_q;
				q_chunk.eoi   = 1'b1;
			end
			F_FLUSH: begin
				q_push        = !q_full;
				q_chunk.flush = 1'b1;
				q_chunk.eoi   = 1'b1;
			end
			default: q_push = 1'b0;
		endcase
	end

	// state, tables and block position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= F_IDLE;
			pos_q      <= '0;
			run_q      <= '0;
			prev_q     <= '0;
			zrl_q      <= 1'b0;
			eob_q      <= 1'b0;
			rd_valid_q <= 1'b0;
			for (int i = 0; i < DcDepth; i++) begin
				dc_code_q[i] <= '0;
				dc_len_q[i]  <= '0;
			end
			for (int i = 0; i < AcDepth; i++)
				ac_valid_q[i] <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ram_re)
				rd_valid_q <= ac_valid_q[ram_raddr];
			if (ram_we)
				ac_valid_q[sym] <= 1'b1;
			if (accept && op == OP_LOAD_DC && sym <= 8'd15 && len <= MAX_LEN) begin
				dc_code_q[sym[3:0]] <= code;
				dc_len_q[sym[3:0]]  <= len;
			end
			if (accept && op == OP_COEF) begin
				if (pos_q == '0) begin
					prev_q <= coef;
					run_q  <= '0;
				end else if (coef == '0 && pos_q != LAST_POS) begin
					run_q <= run_q + 6'd1;
				end
				pos_q <= pos_q + 6'd1;
				zrl_q <= (coef != '0) && (pos_q != '0) && (run_q > 6'd15);
				eob_q <= (coef == '0);
			end
			if (state_q == F_AC_CODE && !q_full) begin
				if (zrl_q) begin
					run_q <= run_next;
					zrl_q <= (run_next > 6'd15);
				end else begin
					run_q <= '0;
				end
			end
		end
	end

	// value bits and category of the current coefficient
	always_ff @(posedge clk) begin
		if (accept && op == OP_COEF) begin
			val_q <= {4'd0, vmask};
			cat_q <= cat;
		end
	end

endmodule

/* hdl/jbhe_back.sv */
// back part: packs bit chunks into bytes msb first, stuffs a zero after 0xff,
// pads on flush and marks the final byte of each item; depends on jbhe_pkg
`timescale 1ns / 1ps

module jbhe_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  jbhe_pkg::chunk_t q_head,
	output logic             q_pop,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,
	output logic             m_tlast
);
	import jbhe_pkg::*;

	back_state_t state_q, state_d;
	logic [22:0] acc_q;
	logic [4:0]  cnt_q;
	logic        eoi_q;
	logic [7:0]  hold_q;
	logic        hold_v_q;
	logic        m_tvalid_q;
	logic [7:0]  m_tdata_q;
	logic        m_tlast_q;

	logic        out_free;
	logic [22:0] shifted;
	logic [7:0]  top_byte;
	logic        emit;
	logic [7:0]  emit_byte;
	logic        out_push;
	logic        out_last;
	logic [22:0] acc_load;
	logic [4:0]  cnt_load;

	assign out_free = !m_tvalid_q || m_tready;
	assign shifted  = acc_q >> (cnt_q - 5'd8);
	assign top_byte = shifted[7:0];

	// accumulator after taking the head chunk
	always_comb begin
		if (q_head.flush) begin
			acc_load = (cnt_q != '0) ? (acc_q << (5'd8 - cnt_q)) : acc_q;
			cnt_load = (cnt_q != '0) ? 5'd8 : 5'd0;
		end else begin
			acc_load = (acc_q << q_head.len) | {7'd0, q_head.bits};
			cnt_load = cnt_q + q_head.len;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_LOAD: begin
				if (!q_empty)
					state_d = B_DRAIN;
			end
			B_DRAIN: begin
				if (cnt_q >= 5'd8) begin
					if ((!hold_v_q || out_free) && top_byte == STUFF_BYTE)
						state_d = B_STUFF;
				end else if (!eoi_q || !hold_v_q || out_free) begin
					state_d = B_LOAD;
				end
			end
			B_STUFF: begin
				if (!hold_v_q || out_free)
					state_d = B_DRAIN;
			end
			default: state_d = B_LOAD;
		endcase
	end

	// byte production and output pushes
	always_comb begin
		q_pop     = 1'b0;
		emit      = 1'b0;
		emit_byte = top_byte;
		out_push  = 1'b0;
		out_last  = 1'b0;
		case (state_q)
			B_LOAD: q_pop = !q_empty;
			B_DRAIN: begin
				if (cnt_q >= 5'd8) begin
					emit     = !hold_v_q || out_free;
					out_push = emit && hold_v_q;
				end else if (eoi_q && hold_v_q && out_free) begin
					out_push = 1'b1;
					out_last = 1'b1;
				end
			end
			B_STUFF: begin
				emit      = !hold_v_q || out_free;
				emit_byte = 8'd0;
				out_push  = emit && hold_v_q;
			end
			default: q_pop = 1'b0;
		endcase
	end

	// packer state and output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_LOAD;
			cnt_q      <= '0;
			eoi_q      <= 1'b0;
			hold_v_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (q_pop) begin
				cnt_q <= cnt_load;
				eoi_q <= q_head.eoi;
			end else if (emit && state_q == B_DRAIN) begin
				cnt_q <= cnt_q - 5'd8;
			end
			if (emit)
				hold_v_q <= 1'b1;
			else if (out_push && out_last)
				hold_v_q <= 1'b0;
			if (out_push)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (q_pop)
			acc_q <= acc_load;
		if (emit)
			hold_q <= emit_byte;
		if (out_push) begin
			m_tdata_q <= hold_q;
			m_tlast_q <= out_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule
